>>> design/dnts_pkg.sv
// Package for the day/night terminator shader: payload types, constants and sine table.
`timescale 1ns / 1ps

package dnts_pkg;

  // Map geometry defaults.
  localparam int unsigned MAP_WIDTH_DEF  = 144;
  localparam int unsigned MAP_HEIGHT_DEF = 72;

  // Angle format: a full turn is 2**ANGLE_BITS.
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned QUARTER_TURN = 16384;

  // Reciprocal used for the angle divisions. The shift covers divisors up to 1024.
  localparam int unsigned RECIP_SHIFT = 10;
  localparam int unsigned RECIP_BITS  = 24;

  // Configuration register indexes.
  localparam logic [7:0] REG_SUN_LONGITUDE = 8'd0;
  localparam logic [7:0] REG_SUN_LATITUDE  = 8'd1;

  // Input word: one map pixel.
  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
    logic       land_bit;
  } pix_t;

  // Output word: one shaded pixel.
  typedef struct packed {
    logic [7:0] col_out;
    logic [6:0] row_out;
    logic       pixel_on;
  } shade_t;

  // Folded angle ready for interpolation.
  typedef struct packed {
    logic [15:0] base;
    logic [11:0] delta;
    logic [8:0]  frac;
    logic        neg;
  } trig_part_t;

  // Quarter-wave sine table, round(65535 * sin(k * pi / 64)).
  function automatic logic [15:0] sin_entry(input logic [5:0] idx);
    logic [15:0] v;
    case (idx)
      6'd0:    v = 16'd0;
      6'd1:    v = 16'd3216;
      6'd2:    v = 16'd6424;
      6'd3:    v = 16'd9616;
      6'd4:    v = 16'd12785;
      6'd5:    v = 16'd15924;
      6'd6:    v = 16'd19024;
      6'd7:    v = 16'd22078;
      6'd8:    v = 16'd25079;
      6'd9:    v = 16'd28020;
      6'd10:   v = 16'd30893;
      6'd11:   v = 16'd33692;
      6'd12:   v = 16'd36409;
      6'd13:   v = 16'd39039;
      6'd14:   v = 16'd41575;
      6'd15:   v = 16'd44011;
      6'd16:   v = 16'd46340;
      6'd17:   v = 16'd48558;
      6'd18:   v = 16'd50659;
      6'd19:   v = 16'd52638;
      6'd20:   v = 16'd54490;
      6'd21:   v = 16'd56211;
      6'd22:   v = 16'd57797;
      6'd23:   v = 16'd59243;
      6'd24:   v = 16'd60546;
      6'd25:   v = 16'd61704;
      6'd26:   v = 16'd62713;
      6'd27:   v = 16'd63571;
      6'd28:   v = 16'd64276;
      6'd29:   v = 16'd64826;
      6'd30:   v = 16'd65219;
      6'd31:   v = 16'd65456;
      6'd32:   v = 16'd65535;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Fold an angle into the first quadrant and look up the table segment.
  function automatic trig_part_t trig_fold(input logic [15:0] angle);
    logic [14:0] p;
    logic [5:0]  idx;
    trig_part_t  r;
    p = {1'b0, angle[13:0]};
    if (angle[14]) begin
      p = 15'(QUARTER_TURN) - p;
    end
    idx = p[14:9];
    r.frac = p[8:0];
    r.neg = angle[15];
    if (idx == 6'd32) begin
      r.base = sin_entry(idx);
      r.delta = '0;
    end else begin
      r.base = sin_entry(idx);
      r.delta = 12'(sin_entry(idx + 6'd1) - sin_entry(idx));
    end
    return r;
  endfunction

endpackage

>>> design/day_night_terminator_shader.sv
// Top level of the day/night terminator shader pipeline.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the pix channel (pix_valid, pix_stall, pix) as one word each: column,
// row and the land bit of the world map. Each accepted word yields exactly one word on
// the shade channel (shade_valid, shade_stall, shade) carrying the same column and row
// and pixel_on, which is the land bit inverted on the night side of the terminator.
// The sun position is set through the cfg channel (register 0 sun longitude, register 1
// sun latitude); cfg_ready is always high, and writes belong to idle periods only.
// The pipeline has seven register stages: a word passes through them in order before it
// shows up on shade, and one word can enter and leave every cycle while shade_stall is
// low. The rate is set by the seven-stage datapath, one item per stage, with the widest
// step being the 34 by 17 multiplier of the triple cosine product.
// Each stage holds its own valid bit and fills when empty, so bubbles close up. When the
// receiver stalls, words stack up in the stages and pix_stall rises only while all seven
// stages are full and shade_stall is high; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets both sun registers to zero.
module day_night_terminator_shader #(
  parameter int unsigned MAP_WIDTH  = dnts_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MAP_HEIGHT = dnts_pkg::MAP_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_stall,
  input  dnts_pkg::pix_t  pix,
  output logic            shade_valid,
  input  logic            shade_stall,
  output dnts_pkg::shade_t shade,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int unsigned NS = 7;
  localparam int unsigned LAT_DIV = 2 * MAP_HEIGHT;
  localparam int unsigned RSH = dnts_pkg::RECIP_SHIFT;
  localparam int unsigned RB = dnts_pkg::RECIP_BITS;
  localparam int unsigned RECIP_W_I =
    (32'd1 << (dnts_pkg::ANGLE_BITS + dnts_pkg::RECIP_SHIFT)) / MAP_WIDTH;
  localparam int unsigned RECIP_H_I =
    (32'd1 << (dnts_pkg::ANGLE_BITS + dnts_pkg::RECIP_SHIFT)) / LAT_DIV;
  localparam logic [RB-1:0] RECIP_W = RB'(RECIP_W_I);
  localparam logic [RB-1:0] RECIP_H = RB'(RECIP_H_I);
  localparam logic [24:0] DIV_W = 25'(MAP_WIDTH);
  localparam logic [24:0] DIV_H = 25'(LAT_DIV);

  // Configuration registers.
  logic [15:0] sun_longitude;
  logic [13:0] sun_latitude;

  // Per-stage valid bits, handshake chain and carried payload.
  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [7:0]    col_q  [NS];
  logic [6:0]    row_q  [NS];
  logic          land_q [NS];

  // Stage 0: reciprocal products.
  logic [31:0] pc_q;
  logic [30:0] pr_q;
  // Stage 1: pixel angles.
  logic [15:0] lon_q;
  logic [15:0] lat_q;
  // Stage 2: folded angles (sin sun, sin pixel, cos sun, cos pixel, cos delta).
  dnts_pkg::trig_part_t part_q [5];
  // Stage 3: trig values.
  logic signed [16:0] tv_q [5];
  // Stage 4: pair products.
  logic signed [33:0] ss_q;
  logic signed [33:0] cc_q;
  logic signed [16:0] c3_q;
  // Stage 5: terms of the cosine sum.
  logic signed [50:0] term_s_q;
  logic signed [50:0] term_c_q;
  // Stage 6: result bit.
  logic pixel_on_q;

  // Combinational values.
  logic [21:0] qe_lon;
  logic [20:0] qe_lat;
  logic [24:0] rem_lon;
  logic [24:0] rem_lat;
  logic [21:0] q_lon;
  logic [20:0] q_lat;
  logic [15:0] sun_lat16;
  logic [15:0] dlon;
  logic [15:0] angle [5];
  logic signed [16:0] tv_next [5];
  logic signed [50:0] ssx;
  logic signed [50:0] ccc;
  logic signed [50:0] sum;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_longitude <= '0;
      sun_latitude <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dnts_pkg::REG_SUN_LONGITUDE: sun_longitude <= cfg_data;
        dnts_pkg::REG_SUN_LATITUDE:  sun_latitude <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage takes a new word when empty or when it hands its word on.
  always_comb begin
    rdy[NS] = !shade_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign pix_stall = !rdy[0];

  // Valid bits and carried pixel fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pix_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      col_q[0] <= pix.col;
      row_q[0] <= pix.row;
      land_q[0] <= pix.land_bit;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        col_q[k] <= col_q[k-1];
        row_q[k] <= row_q[k-1];
        land_q[k] <= land_q[k-1];
      end
    end
  end

  // Stage 0: multiply column and row by the divisor reciprocals.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pc_q <= 32'(pix.col) * 32'(RECIP_W);
      pr_q <= 31'(pix.row) * 31'(RECIP_H);
    end
  end

  // Stage 1: the quotient estimate is low by at most one; correct it from the remainder.
  always_comb begin
    qe_lon = pc_q[31:RSH];
    qe_lat = pr_q[30:RSH];
    rem_lon = {1'b0, col_q[0], 16'b0} - 25'(25'(qe_lon) * DIV_W);
    rem_lat = {2'b0, row_q[0], 16'b0} - 25'(25'(qe_lat) * DIV_H);
    q_lon = (rem_lon >= DIV_W) ? qe_lon + 22'd1 : qe_lon;
    q_lat = (rem_lat >= DIV_H) ? qe_lat + 21'd1 : qe_lat;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      lon_q <= q_lon[15:0];
      lat_q <= q_lat[15:0] - 16'(dnts_pkg::QUARTER_TURN);
    end
  end

  // Stage 2: form the five angles, fold them and read the sine table.
  always_comb begin
    sun_lat16 = {{2{sun_latitude[13]}}, sun_latitude};
    dlon = sun_longitude - lon_q;
    angle[0] = sun_lat16;
    angle[1] = lat_q;
    angle[2] = sun_lat16 + 16'(dnts_pkg::QUARTER_TURN);
    angle[3] = lat_q + 16'(dnts_pkg::QUARTER_TURN);
    angle[4] = dlon + 16'(dnts_pkg::QUARTER_TURN);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int k = 0; k < 5; k++) begin
        part_q[k] <= dnts_pkg::trig_fold(angle[k]);
      end
    end
  end

  // Stage 3: linear interpolation between table entries, then the quadrant sign.
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      logic [21:0] step;
      logic [16:0] mag;
      step = 22'(part_q[k].delta) * 22'(part_q[k].frac) + 22'd256;
      mag = 17'(part_q[k].base) + 17'(step[21:9]);
      tv_next[k] = part_q[k].neg ? -$signed(mag) : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 5; k++) begin
        tv_q[k] <= tv_next[k];
      end
    end
  end

  // Stage 4: sine product and first cosine product.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      ss_q <= 34'(tv_q[0]) * 34'(tv_q[1]);
      cc_q <= 34'(tv_q[2]) * 34'(tv_q[3]);
      c3_q <= tv_q[4];
    end
  end

  // Stage 5: scale the sine product by 65535 and finish the cosine triple product.
  always_comb begin
    ssx = 51'(ss_q);
    ccc = 51'(cc_q) * 51'(c3_q);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      term_s_q <= (ssx <<< 16) - ssx;
      term_c_q <= ccc;
    end
  end

  // Stage 6: night when the sum is negative; a zero sum counts as day.
  assign sum = term_s_q + term_c_q;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      pixel_on_q <= land_q[5] ^ sum[50];
    end
  end

  // Output word.
  assign shade_valid = vld[NS-1];
  assign shade.col_out = col_q[NS-1];
  assign shade.row_out = row_q[NS-1];
  assign shade.pixel_on = pixel_on_q;

`ifndef SYNTHESIS
  // Input is held off only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (&vld))
    else $error("input stalled while a stage is empty");

  // The reciprocal estimate is never more than one below the true quotient.
  a_lon_rem: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (rem_lon < (DIV_W << 1)))
    else $error("longitude quotient estimate out of range");

  a_lat_rem: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (rem_lat < (DIV_H << 1)))
    else $error("latitude quotient estimate out of range");

  // Interpolated trig values stay within plus or minus 65535.
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (tv_q[0] != -17'sd65536 && tv_q[1] != -17'sd65536 &&
                tv_q[2] != -17'sd65536 && tv_q[3] != -17'sd65536 &&
                tv_q[4] != -17'sd65536))
    else $error("trig value out of range");
`endif

endmodule
